// ----- rtl/gsfr_pkg.sv -----
`timescale 1ns / 1ps

package gsfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 4;
    localparam int READING_W = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int M_DATA_W  = 24;

    localparam logic [BYTE_W-1:0] START_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_ACTIVE   = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_QUESTION = 8'h86;

    localparam logic [POS_W-1:0] POS_HUNT       = 4'd0;
    localparam logic [POS_W-1:0] POS_CMD        = 4'd1;
    localparam logic [POS_W-1:0] POS_FIRST_DATA = 4'd2;
    localparam logic [POS_W-1:0] POS_LAST       = 4'd8;
    localparam logic [POS_W-1:0] HI_POS_ACTIVE   = 4'd4;
    localparam logic [POS_W-1:0] HI_POS_QUESTION = 4'd2;

    localparam logic [STATUS_W-1:0] STATUS_VALID    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 8'd1;

    localparam logic [READING_W-1:0] RANGE_LIMIT_RESET = 16'd10000;

    typedef struct packed {
        logic                  valid;
        logic [STATUS_W-1:0]   status;
        logic [READING_W-1:0]  reading;
    } gsfr_result_t;

endpackage

// ----- rtl/gsfr_parser.sv -----
`timescale 1ns / 1ps

module gsfr_parser
    import gsfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  byte_accept,
    input  logic [BYTE_W-1:0]     rx_byte,
    input  logic                  frame_mode,
    input  logic [READING_W-1:0]  range_limit_ppb,
    output logic                  at_last,
    output gsfr_result_t          result
);

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [BYTE_W-1:0]    sum_reg, sum_next;
    logic [READING_W-1:0] value_reg, value_next;

    logic [POS_W-1:0]  hi_pos;
    logic [POS_W-1:0]  lo_pos;
    logic [BYTE_W-1:0] want_cmd;
    logic [BYTE_W-1:0] expect_sum;

    assign hi_pos     = frame_mode ? HI_POS_QUESTION : HI_POS_ACTIVE;
    assign lo_pos     = hi_pos + POS_W'(1);
    assign want_cmd   = frame_mode ? CMD_QUESTION : CMD_ACTIVE;
    assign expect_sum = BYTE_W'(0) - sum_reg;
    assign at_last    = (pos_reg == POS_LAST);

    always_comb begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        value_next = value_reg;
        result     = '0;
        if (byte_accept) begin
            priority if (pos_reg == POS_CMD) begin
                if (rx_byte == want_cmd) begin
                    pos_next   = POS_FIRST_DATA;
                    sum_next   = rx_byte;
                    value_next = '0;
                end else if (rx_byte == START_BYTE) begin
                    pos_next = POS_CMD;
                    sum_next = '0;
                end else begin
                    pos_next = POS_HUNT;
                    sum_next = '0;
                end
            end else if (pos_reg >= POS_FIRST_DATA && pos_reg < POS_LAST) begin
                sum_next = sum_reg + rx_byte;
                if (pos_reg == hi_pos) begin
                    value_next = {rx_byte, value_reg[BYTE_W-1:0]};
                end else if (pos_reg == lo_pos) begin
                    value_next = {value_reg[READING_W-1:BYTE_W], rx_byte};
                end
                pos_next = pos_reg + POS_W'(1);
            end else if (pos_reg == POS_LAST) begin
                result.valid = 1'b1;
                if (rx_byte != expect_sum) begin
                    result.status  = STATUS_CHECKSUM;
                    result.reading = '0;
                end else if (value_reg > range_limit_ppb) begin
                    result.status  = STATUS_RANGE;
                    result.reading = value_reg;
                end else begin
                    result.status  = STATUS_VALID;
                    result.reading = value_reg;
                end
                pos_next   = POS_HUNT;
                sum_next   = '0;
                value_next = '0;
            end else begin
                // hunting for start byte
                pos_next   = (rx_byte == START_BYTE) ? POS_CMD : POS_HUNT;
                sum_next   = '0;
                value_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_HUNT;
            sum_reg   <= '0;
            value_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            value_reg <= value_next;
        end
    end

endmodule

// ----- rtl/gas_sensor_frame_receiver_top.sv -----
`timescale 1ns / 1ps
// output: result registered onto m_tdata in the cycle after the checksum byte transaction
// throughput: one byte per cycle; input stalls only when a checksum byte
//   arrives while the previous result is still held and m_tready is low
// reset: synchronous active-low aresetn clears frame state and result valid,
//   sets frame_mode to active upload and range limit to 10000 ppb

module gas_sensor_frame_receiver_top
    import gsfr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,    // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_W-1:0]    m_tdata,    // [1:0] frame_status, [17:2] reading_ppb
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                 frame_mode_reg, frame_mode_next;
    logic [READING_W-1:0] range_limit_reg, range_limit_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [READING_W-1:0] reading_reg, reading_next;

    logic         byte_accept;
    logic         at_last;
    gsfr_result_t result;

    assign cfg_ready   = 1'b1;
    assign s_tready    = !at_last || !m_valid_reg || m_tready;
    assign byte_accept = s_tvalid && s_tready;

    gsfr_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .byte_accept     (byte_accept),
        .rx_byte         (s_tdata[BYTE_W-1:0]),
        .frame_mode      (frame_mode_reg),
        .range_limit_ppb (range_limit_reg),
        .at_last         (at_last),
        .result          (result)
    );

    always_comb begin
        frame_mode_next  = frame_mode_reg;
        range_limit_next = range_limit_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_FRAME_MODE) begin
                frame_mode_next = cfg_data[0];
            end else if (cfg_index == REG_RANGE_LIMIT) begin
                range_limit_next = cfg_data;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        reading_next = reading_reg;
        if (result.valid) begin
            m_valid_next = 1'b1;
            status_next  = result.status;
            reading_next = result.reading;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_mode_reg  <= 1'b0;
            range_limit_reg <= RANGE_LIMIT_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            frame_mode_reg  <= frame_mode_next;
            range_limit_reg <= range_limit_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        reading_reg <= reading_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - STATUS_W - READING_W){1'b0}}, reading_reg, status_reg};

    a_checksum_byte_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        byte_accept && at_last |=> m_tvalid
    ) else $error("checksum byte did not produce a result");

    a_stall_only_on_full_output: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (at_last && m_tvalid && !m_tready)
    ) else $error("input stalled without a held result");

    a_mismatch_reading_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status_reg == STATUS_CHECKSUM) |-> (reading_reg == '0)
    ) else $error("checksum mismatch result carries a reading");

    a_status_code_known: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (status_reg == STATUS_VALID || status_reg == STATUS_CHECKSUM
                      || status_reg == STATUS_RANGE)
    ) else $error("unknown frame status on output");

endmodule

// ----- test/gas_sensor_frame_receiver_top_tb.sv -----
`timescale 1ns / 1ps

module gas_sensor_frame_receiver_top_tb;
    import gsfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;
    localparam int BYTE_TARGET    = 750;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [READING_W-1:0] reading;
    } reading_t;

    class frame_scoreboard;
        logic                 frame_mode;
        logic [READING_W-1:0] limit_ppb;
        logic [POS_W-1:0]     position;
        logic [BYTE_W-1:0]    checksum_acc;
        logic [READING_W-1:0] reading_acc;
        reading_t             expected_q[$];
        int                   errors;

        function new();
            frame_mode   = 1'b0;
            limit_ppb    = RANGE_LIMIT_RESET;
            position     = POS_HUNT;
            checksum_acc = '0;
            reading_acc  = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_FRAME_MODE) begin
                frame_mode = data[0];
            end else if (idx == REG_RANGE_LIMIT) begin
                limit_ppb = data[READING_W-1:0];
            end
        endfunction

        // rx byte transaction accepted
        function void note_byte(logic [BYTE_W-1:0] b);
            logic [POS_W-1:0]  hi_pos;
            logic [BYTE_W-1:0] want;
            reading_t          res;
            hi_pos = frame_mode ? HI_POS_QUESTION : HI_POS_ACTIVE;
            want   = frame_mode ? CMD_QUESTION : CMD_ACTIVE;
            if (position == POS_HUNT || position > POS_LAST) begin
                position     = (b == START_BYTE) ? POS_CMD : POS_HUNT;
                checksum_acc = '0;
                reading_acc  = '0;
            end else if (position == POS_CMD) begin
                if (b == want) begin
                    checksum_acc = b;
                    reading_acc  = '0;
                    position     = POS_FIRST_DATA;
                end else begin
                    position     = (b == START_BYTE) ? POS_CMD : POS_HUNT;
                    checksum_acc = '0;
                end
            end else if (position < POS_LAST) begin
                checksum_acc = checksum_acc + b;
                if (position == hi_pos) begin
                    reading_acc[15:8] = b;
                end else if (position == hi_pos + 4'd1) begin
                    reading_acc[7:0] = b;
                end
                position = position + 4'd1;
            end else begin
                if (b != 8'(8'h00 - checksum_acc)) begin
                    res.status  = STATUS_CHECKSUM;
                    res.reading = '0;
                end else if (reading_acc > limit_ppb) begin
                    res.status  = STATUS_RANGE;
                    res.reading = reading_acc;
                end else begin
                    res.status  = STATUS_VALID;
                    res.reading = reading_acc;
                end
                expected_q.push_back(res);
                position     = POS_HUNT;
                checksum_acc = '0;
                reading_acc  = '0;
            end
        endfunction

        function void report(string what, logic [M_DATA_W-1:0] exp_val,
                             logic [M_DATA_W-1:0] act_val);
            if (errors < MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, exp_val, act_val);
            end
            errors++;
        endfunction

        // result transaction accepted
        function void check_result(logic [M_DATA_W-1:0] data);
            reading_t want;
            if (expected_q.size() == 0) begin
                if (errors < MAX_REPORTS) begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, data);
                end
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (data[STATUS_W-1:0] !== want.status) begin
                report("frame_status", want.status, data[STATUS_W-1:0]);
            end
            if (data[STATUS_W+READING_W-1:STATUS_W] !== want.reading) begin
                report("reading_ppb", want.reading, data[STATUS_W+READING_W-1:STATUS_W]);
            end
            if (data[M_DATA_W-1:STATUS_W+READING_W] !== '0) begin
                report("tdata padding", '0, data[M_DATA_W-1:STATUS_W+READING_W]);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frame_scoreboard   sb;
    logic [BYTE_W-1:0] tx_q[$];
    int                tx_gap_max;
    int                rx_stall_max;
    int                byte_count;
    int                idle_cycles;

    gas_sensor_frame_receiver_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // result side backpressure
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        byte_count++;
        @(negedge aclk);
    endtask

    task automatic send_all();
        while (tx_q.size() > 0) begin
            send_byte(tx_q.pop_front());
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
    endtask

    task automatic configure(input logic mode, input logic [READING_W-1:0] limit);
        write_reg(REG_FRAME_MODE, {15'd0, mode});
        write_reg(REG_RANGE_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    // wait for outstanding results plus the output register stage
    task automatic settle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void push_frame(logic use_question, logic [READING_W-1:0] reading,
                                       bit corrupt, int count);
        logic [BYTE_W-1:0] fb [9];
        logic [BYTE_W-1:0] sum;
        int                hi;
        hi    = use_question ? int'(HI_POS_QUESTION) : int'(HI_POS_ACTIVE);
        fb[0] = START_BYTE;
        fb[1] = use_question ? CMD_QUESTION : CMD_ACTIVE;
        for (int i = 2; i < 8; i++) fb[i] = 8'($urandom_range(0, 255));
        fb[hi]     = reading[15:8];
        fb[hi + 1] = reading[7:0];
        sum = '0;
        for (int i = 1; i < 8; i++) sum = sum + fb[i];
        fb[8] = 8'h00 - sum;
        if (corrupt) fb[8] = fb[8] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < count; i++) tx_q.push_back(fb[i]);
    endfunction

    function automatic logic [READING_W-1:0] pick_reading();
        case ($urandom_range(0, 5))
            0: return sb.limit_ppb;
            1: return sb.limit_ppb + 16'd1;
            2: return sb.limit_ppb - 16'd1;
            3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [READING_W-1:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return RANGE_LIMIT_RESET;
            1: return 16'($urandom_range(0, 300));
            2: return 16'hFFFF - 16'($urandom_range(0, 300));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void add_random_item();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            push_frame(sb.frame_mode, pick_reading(), $urandom_range(0, 7) == 0, 9);
        end else if (r < 75) begin
            // frame carrying the other mode's command
            push_frame(!sb.frame_mode, pick_reading(), 1'b0, 9);
        end else if (r < 85) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                tx_q.push_back(($urandom_range(0, 3) == 0) ? START_BYTE
                                                           : 8'($urandom_range(0, 255)));
            end
        end else if (r < 92) begin
            tx_q.push_back(START_BYTE);
            push_frame(sb.frame_mode, pick_reading(), 1'b0, 9);
        end else begin
            push_frame(sb.frame_mode, pick_reading(), 1'b0, $urandom_range(2, 8));
        end
    endfunction

    initial begin
        int phase;
        int phase_len;
        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        tx_gap_max   = 13;
        rx_stall_max = 13;
        byte_count   = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // wrong command, repeated start byte, reading equal to the limit
        tx_q = '{8'h00, START_BYTE, CMD_QUESTION, START_BYTE};
        push_frame(1'b0, RANGE_LIMIT_RESET, 1'b0, 9);
        send_all();
        settle();
        write_reg(REG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;

        // mode switch in the middle of an active frame
        tx_q = '{START_BYTE, CMD_ACTIVE};
        send_all();
        settle();
        configure(1'b1, 16'h0000);
        tx_q = '{8'hFF, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h44, 8'h2E};
        send_all();
        settle();

        // checksum mismatch
        configure(1'b1, 16'hFFFF);
        push_frame(1'b1, 16'h0000, 1'b1, 9);
        send_all();
        settle();

        phase = 0;
        while (byte_count < BYTE_TARGET) begin
            tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 13;
            rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
            if (phase == 2) begin
                tx_gap_max   = 0;
                rx_stall_max = 0;
            end
            phase_len = $urandom_range(60, 140);
            while (tx_q.size() < phase_len) add_random_item();
            send_all();
            settle();
            case (phase)
                0: configure(1'b0, 16'hFFFF);
                1: configure(1'b1, 16'h0000);
                default: configure(1'($urandom_range(0, 1)), pick_limit());
            endcase
            phase++;
        end

        settle();
        repeat (5) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
